// ----- design/bfcs_pkg.sv -----
// ----------------------------------------------------------------------------
// bfcs_pkg
// Shared widths, constants, controller state and command/status types for
// the best-flip candidate selector.
// ----------------------------------------------------------------------------
package bfcs_pkg;

  localparam int unsigned MAX_VARS_DEF = 4096;

  localparam int unsigned SCORE_W  = 17;
  localparam int unsigned CLAUSE_W = 16;
  localparam int unsigned RND_W    = 32;
  localparam int unsigned FLIP_W   = 13;

  localparam logic [CLAUSE_W-1:0] CLAUSE_RST = 16'hFFFF;

  // one remainder bit per divide step
  localparam int unsigned DIV_STEPS = RND_W;
  localparam int unsigned DIV_CNT_W = $clog2(DIV_STEPS);

  typedef enum logic [1:0] {
    ST_SCAN,
    ST_DIV,
    ST_READ,
    ST_LOAD
  } bfcs_state_t;

  typedef struct packed {
    logic take;      // input beat taken this cycle
    logic div_step;  // advance remainder by one bit
    logic ram_rd;    // read the picked candidate
    logic out_load;  // load the result register
  } bfcs_cmd_t;

  typedef struct packed {
    logic improving; // minimum below zero with at least one candidate
    logic multi;     // more than one tied candidate
    logic out_free;  // result register can take a new beat
  } bfcs_status_t;

endpackage

// ----- design/bfcs_ifs.sv -----
// ----------------------------------------------------------------------------
// bfcs channel interfaces
// Valid/ready channels for score input, result output and configuration.
// ----------------------------------------------------------------------------
interface bfcs_in_if;
  logic                                valid;
  logic                                ready;
  logic signed [bfcs_pkg::SCORE_W-1:0] var_score;
  logic                                is_last;
  logic        [bfcs_pkg::RND_W-1:0]   random_word;

  modport source (output valid, output var_score, output is_last, output random_word,
                  input ready);
  modport sink   (input valid, input var_score, input is_last, input random_word,
                  output ready);
endinterface

interface bfcs_out_if;
  logic                          valid;
  logic                          ready;
  logic [bfcs_pkg::FLIP_W-1:0]   flip_var;
  logic                          restart;

  modport source (output valid, output flip_var, output restart, input ready);
  modport sink   (input valid, input flip_var, input restart, output ready);
endinterface

interface bfcs_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [bfcs_pkg::CLAUSE_W-1:0]   clause_count;

  modport source (output valid, output clause_count, input ready);
  modport sink   (input valid, input clause_count, output ready);
endinterface

// ----- design/bfcs_ram.sv -----
// ----------------------------------------------------------------------------
// bfcs_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module bfcs_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ----- design/bfcs_ctrl.sv -----
// ----------------------------------------------------------------------------
// bfcs_ctrl
// Sequencer: scan, remainder division, candidate read, result load.
// ----------------------------------------------------------------------------
module bfcs_ctrl (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  input  logic                   in_last,
  output logic                   in_ready,
  input  bfcs_pkg::bfcs_status_t status,
  output bfcs_pkg::bfcs_cmd_t    cmd
);
  import bfcs_pkg::*;

  bfcs_state_t          state_r, state_nxt;
  logic [DIV_CNT_W-1:0] step_r, step_nxt;
  logic                 take;

  assign in_ready = (state_r == ST_SCAN);
  assign take     = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_SCAN;
      step_r  <= '0;
    end else begin
      state_r <= state_nxt;
      step_r  <= step_nxt;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    step_nxt  = step_r;
    case (state_r)
      ST_SCAN: begin
        step_nxt = '0;
        if (take && in_last) begin
          if (!status.improving) begin
            state_nxt = ST_LOAD;
          end else if (status.multi) begin
            state_nxt = ST_DIV;
          end else begin
            state_nxt = ST_READ;
          end
        end
      end
      ST_DIV: begin
        step_nxt = step_r + 1'b1;
        if (step_r == DIV_CNT_W'(DIV_STEPS - 1)) begin
          state_nxt = ST_READ;
        end
      end
      ST_READ: begin
        state_nxt = ST_LOAD;
      end
      ST_LOAD: begin
        if (status.out_free) begin
          state_nxt = ST_SCAN;
        end
      end
      default: begin
        state_nxt = ST_SCAN;
      end
    endcase
  end

  // outputs
  always_comb begin
    cmd = '0;
    case (state_r)
      ST_SCAN: cmd.take     = take;
      ST_DIV:  cmd.div_step = 1'b1;
      ST_READ: cmd.ram_rd   = 1'b1;
      ST_LOAD: cmd.out_load = status.out_free;
      default: cmd = '0;
    endcase
  end

endmodule

// ----- design/bfcs_dpath.sv -----
// ----------------------------------------------------------------------------
// bfcs_dpath
// Running minimum, tie list, restoring remainder unit and result register.
// ----------------------------------------------------------------------------
module bfcs_dpath #(
  parameter int unsigned MAX_VARS = bfcs_pkg::MAX_VARS_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  bfcs_pkg::bfcs_cmd_t                 cmd,
  output bfcs_pkg::bfcs_status_t              status,
  input  logic signed [bfcs_pkg::SCORE_W-1:0] in_score,
  input  logic                                in_last,
  input  logic        [bfcs_pkg::RND_W-1:0]   in_rnd,
  input  logic                                cfg_valid,
  input  logic        [bfcs_pkg::CLAUSE_W-1:0] cfg_clause,
  input  logic                                out_ready,
  output logic                                out_valid,
  output logic        [bfcs_pkg::FLIP_W-1:0]  out_flip,
  output logic                                out_restart
);
  import bfcs_pkg::*;

  localparam int unsigned CW = $clog2(MAX_VARS + 1);
  localparam int unsigned AW = $clog2(MAX_VARS);

  logic [CLAUSE_W-1:0]       clause_r;
  logic [CW-1:0]             var_cnt_r;
  logic [CW-1:0]             cand_cnt_r;
  logic signed [SCORE_W-1:0] best_r;

  logic                      scan_start;
  logic signed [SCORE_W-1:0] best_eff;
  logic [CW-1:0]             cnt_eff;
  logic                      room;
  logic [CW-1:0]             var_idx;
  logic                      hit, lower;
  logic signed [SCORE_W-1:0] best_nxt;
  logic [CW-1:0]             cnt_nxt;
  logic [CW-1:0]             var_nxt;

  logic [RND_W-1:0]          dvd_r;
  logic [CW-1:0]             dvs_r;
  logic [CW-1:0]             rem_r;
  logic                      restart_r;
  logic [CW:0]               rem_sh;
  logic [CW:0]               rem_diff;

  logic                      ram_we;
  logic [AW-1:0]             ram_waddr;
  logic [FLIP_W-1:0]         ram_rdata;

  logic                      out_valid_r;
  logic [FLIP_W-1:0]         out_flip_r;
  logic                      out_restart_r;

  // candidate tracking for the beat at the input
  always_comb begin
    scan_start = (var_cnt_r == '0);
    best_eff   = scan_start ? $signed({1'b0, clause_r}) : best_r;
    cnt_eff    = scan_start ? '0 : cand_cnt_r;
    room       = (var_cnt_r < CW'(MAX_VARS));
    var_idx    = var_cnt_r + 1'b1;
    hit        = room && (in_score <= best_eff);
    lower      = room && (in_score < best_eff);
    best_nxt   = lower ? in_score : best_eff;
    cnt_nxt    = lower ? CW'(1) : (hit ? cnt_eff + 1'b1 : cnt_eff);
    var_nxt    = room ? var_idx : var_cnt_r;
  end

  assign status.improving = best_nxt[SCORE_W-1] && (cnt_nxt != '0);
  assign status.multi     = (cnt_nxt > CW'(1));
  assign status.out_free  = !out_valid_r || out_ready;

  assign ram_we    = cmd.take && hit;
  assign ram_waddr = lower ? '0 : cnt_eff[AW-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clause_r   <= CLAUSE_RST;
      var_cnt_r  <= '0;
      cand_cnt_r <= '0;
    end else begin
      if (cfg_valid) begin
        clause_r <= cfg_clause;
      end
      if (cmd.take) begin
        if (in_last) begin
          var_cnt_r  <= '0;
          cand_cnt_r <= '0;
        end else begin
          var_cnt_r  <= var_nxt;
          cand_cnt_r <= cnt_nxt;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.take) begin
      best_r <= best_nxt;
    end
  end

  // restoring remainder, one quotient bit per step
  assign rem_sh   = {rem_r, dvd_r[RND_W-1]};
  assign rem_diff = rem_sh - {1'b0, dvs_r};

  always_ff @(posedge clk) begin
    if (cmd.take && in_last) begin
      dvd_r     <= in_rnd;
      dvs_r     <= cnt_nxt;
      rem_r     <= '0;
      restart_r <= !status.improving;
    end else if (cmd.div_step) begin
      dvd_r <= dvd_r << 1;
      if (rem_sh >= {1'b0, dvs_r}) begin
        rem_r <= rem_diff[CW-1:0];
      end else begin
        rem_r <= rem_sh[CW-1:0];
      end
    end
  end

  bfcs_ram #(
    .WIDTH (FLIP_W),
    .DEPTH (MAX_VARS)
  ) u_cand_ram (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (ram_waddr),
    .wr_data (FLIP_W'(var_idx)),
    .rd_en   (cmd.ram_rd),
    .rd_addr (rem_r[AW-1:0]),
    .rd_data (ram_rdata)
  );

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_flip_r    <= restart_r ? '0 : ram_rdata;
      out_restart_r <= restart_r;
    end
  end

  assign out_valid   = out_valid_r;
  assign out_flip    = out_flip_r;
  assign out_restart = out_restart_r;

endmodule

// ----- design/best_flip_candidate_select.sv -----
// ----------------------------------------------------------------------------
// best_flip_candidate_select
// Greedy best-flip selector: tracks the minimum flip score over a scan, keeps
// every variable tied at it, and at scan end picks one at random or signals restart.
// ----------------------------------------------------------------------------
//
//   channel   dir   beat contents                       accepted when
//   --------  ----  ----------------------------------  ------------------
//   in_chan   in    var_score, is_last, random_word     valid && ready
//   out_chan  out   flip_var, restart                   valid && ready
//   cfg_chan  in    clause_count                        valid && ready
//
// Score beats are taken one per cycle during a scan. After the last beat the
// input stalls for the end-of-scan work: with two or more tied candidates,
// 32 remainder steps, one candidate RAM read and one result load; with a
// single candidate, the read and load; on a restart, the load alone.
// A waiting result does not stop the next scan; it holds the following load,
// with the input stalled, until the waiting beat is taken.
// Reset clears the counters and the result valid; the candidate RAM needs no
// clearing since only entries written in the current scan are ever read.
//
module best_flip_candidate_select #(
  parameter int unsigned MAX_VARS = bfcs_pkg::MAX_VARS_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  bfcs_in_if.sink    in_chan,
  bfcs_out_if.source out_chan,
  bfcs_cfg_if.sink   cfg_chan
);
  import bfcs_pkg::*;

  bfcs_cmd_t    cmd;
  bfcs_status_t status;
  logic         in_ready;

  // configuration is always taken; the register is read at the next scan start
  assign cfg_chan.ready = 1'b1;
  assign in_chan.ready  = in_ready;

  // sequencer: hold the input off while the scan result is worked out
  bfcs_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_chan.valid),
    .in_last  (in_chan.is_last),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  // datapath: minimum tracking, tie list, remainder unit, result register
  bfcs_dpath #(
    .MAX_VARS (MAX_VARS)
  ) u_dpath (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .status      (status),
    .in_score    (in_chan.var_score),
    .in_last     (in_chan.is_last),
    .in_rnd      (in_chan.random_word),
    .cfg_valid   (cfg_chan.valid),
    .cfg_clause  (cfg_chan.clause_count),
    .out_ready   (out_chan.ready),
    .out_valid   (out_chan.valid),
    .out_flip    (out_chan.flip_var),
    .out_restart (out_chan.restart)
  );

endmodule

// ----- tb/sv/best_flip_candidate_select_test.sv -----
// ----------------------------------------------------------------------------
// best_flip_candidate_select_test
// Self-checking bench for the best-flip selector. Streams scans of signed
// scores with random tie-break words. A built-in tracker of the running
// minimum and its tied candidates predicts the chosen variable or restart for
// every scan, and each result beat is compared with that prediction. The run
// covers several clause counts and three sender/receiver stall mixes.
// ----------------------------------------------------------------------------
module best_flip_candidate_select_test;
  timeunit 1ns;
  timeprecision 1ps;

  import bfcs_pkg::*;

  localparam int unsigned VAR_LIMIT    = MAX_VARS_DEF;
  // end-of-scan work is at most the remainder steps plus read and load
  localparam int unsigned SETTLE_CYC   = DIV_STEPS + 8;
  localparam int unsigned STALL_LIMIT  = 4000;
  localparam int unsigned PHASE_BEATS  = 420;

  typedef struct packed {
    logic [SCORE_W-1:0] score;
    logic               is_last;
    logic [RND_W-1:0]   rnd;
  } score_beat_t;

  typedef struct packed {
    logic [FLIP_W-1:0] flip_var;
    logic              restart;
  } flip_t;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  bfcs_in_if  score_ch ();
  bfcs_out_if flip_ch ();
  bfcs_cfg_if cfg_ch ();

  best_flip_candidate_select u_top (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (score_ch),
    .out_chan (flip_ch),
    .cfg_chan (cfg_ch)
  );

  // 10 ns period
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Beats waiting to be sent, and results still owed by the block.
  score_beat_t score_queue[$];
  flip_t       flips_due[$];

  // Stall mix, in percent of cycles.
  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  int unsigned err_count     = 0;
  int unsigned idle_cycles   = 0;

  // Tracker state: mirrors the block's scan registers and candidate list.
  logic [CLAUSE_W-1:0] clause_shadow = CLAUSE_RST;
  int unsigned         scan_vars     = 0;
  int unsigned         cand_total    = 0;
  int                  best_min      = int'(CLAUSE_RST);
  logic [FLIP_W-1:0]   cand_list [VAR_LIMIT];

  // Advance the tracker by one accepted score beat; on the last beat of a
  // scan, queue the flip (or restart) the block has to return.
  function automatic void track_score(input score_beat_t b);
    int          s;
    int unsigned pick;
    flip_t       r;
    s = $signed(b.score);
    // Scan start: the minimum restarts from the clause count in force now.
    if (scan_vars == 0) begin
      best_min   = int'(clause_shadow);
      cand_total = 0;
    end
    // Past the variable limit, beats only matter for their last mark.
    if (scan_vars < VAR_LIMIT) begin
      scan_vars++;
      if (s <= best_min) begin
        // A strictly lower score drops every earlier tie.
        if (s < best_min) begin
          cand_total = 0;
          best_min   = s;
        end
        if (cand_total < VAR_LIMIT) begin
          cand_list[cand_total] = scan_vars[FLIP_W-1:0];
          cand_total++;
        end
      end
    end
    if (b.is_last) begin
      if (best_min < 0 && cand_total > 0) begin
        pick       = (cand_total > 1) ? b.rnd % cand_total : 0;
        r.flip_var = cand_list[pick];
        r.restart  = 1'b0;
      end else begin
        // No improving flip: ask for a restart.
        r.flip_var = '0;
        r.restart  = 1'b1;
      end
      flips_due.push_back(r);
      scan_vars  = 0;
      cand_total = 0;
      best_min   = int'(clause_shadow);
    end
  endfunction

  function automatic void push_beat(input int s, input logic last, input logic [RND_W-1:0] rnd);
    score_beat_t b;
    b.score   = s[SCORE_W-1:0];
    b.is_last = last;
    b.rnd     = rnd;
    score_queue.push_back(b);
  endfunction

  // Queue one scan. Scores mostly sit in a narrow band near zero so that
  // ties and both outcomes are common; a few span -65535 to 65535.
  function automatic void queue_scan(input int unsigned n_vars);
    int          lo;
    int unsigned spread;
    int          s;
    lo     = int'($urandom_range(8)) - 6;
    spread = $urandom_range(6);
    for (int unsigned i = 1; i <= n_vars; i++) begin
      if ($urandom_range(9) == 0)
        s = int'($urandom_range(131070)) - 65535;
      else
        s = lo + int'(spread == 0 ? 0 : $urandom_range(spread));
      push_beat(s, i == n_vars, $urandom());
    end
  endfunction

  // Score driver: hold a beat until it is taken, then pull the next one
  // from the queue or idle according to the current stall mix.
  always @(posedge clk) begin : score_driver
    score_beat_t nxt;
    if (!rst_n) begin
      score_ch.valid <= 1'b0;
    end else begin
      if (score_ch.valid && score_ch.ready) begin
        track_score({score_ch.var_score, score_ch.is_last, score_ch.random_word});
      end
      if (!score_ch.valid || score_ch.ready) begin
        if (score_queue.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          nxt                  = score_queue.pop_front();
          score_ch.var_score   <= nxt.score;
          score_ch.is_last     <= nxt.is_last;
          score_ch.random_word <= nxt.rnd;
          score_ch.valid       <= 1'b1;
        end else begin
          score_ch.valid <= 1'b0;
        end
      end
    end
  end

  // Result monitor: check each taken beat against the oldest prediction,
  // then pick the next cycle's ready from the stall mix.
  always @(posedge clk) begin : result_check
    flip_t want;
    if (!rst_n) begin
      flip_ch.ready <= 1'b0;
    end else begin
      if (flip_ch.valid && flip_ch.ready) begin
        if (flips_due.size() == 0) begin
          $display("%0t: result with none pending, got flip_var=%0d restart=%0b",
                   $time, flip_ch.flip_var, flip_ch.restart);
          err_count++;
        end else begin
          want = flips_due.pop_front();
          if (flip_ch.flip_var !== want.flip_var) begin
            $display("%0t: flip_var mismatch, expected %0d, got %0d",
                     $time, want.flip_var, flip_ch.flip_var);
            err_count++;
          end
          if (flip_ch.restart !== want.restart) begin
            $display("%0t: restart mismatch, expected %0b, got %0b",
                     $time, want.restart, flip_ch.restart);
            err_count++;
          end
        end
      end
      flip_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Watchdog: count cycles without any beat on any channel.
  always @(posedge clk) begin
    if (rst_n) begin
      if ((score_ch.valid && score_ch.ready) || (flip_ch.valid && flip_ch.ready) ||
          (cfg_ch.valid && cfg_ch.ready)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= STALL_LIMIT) begin
        $display("%0t: no beat for %0d cycles", $time, STALL_LIMIT);
        $display("RESULT: ERROR");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  // Hold until every queued beat is sent and every result is back, then let
  // the block finish any end-of-scan work.
  task automatic wait_drained();
    do @(posedge clk);
    while (score_queue.size() != 0 || score_ch.valid || flips_due.size() != 0);
    repeat (SETTLE_CYC) @(posedge clk);
  endtask

  // Write clause_count; only called while the block is idle.
  task automatic write_clause_count(input logic [CLAUSE_W-1:0] value);
    @(posedge clk);
    cfg_ch.valid        <= 1'b1;
    cfg_ch.clause_count <= value;
    do @(posedge clk);
    while (!cfg_ch.ready);
    clause_shadow = value;
    cfg_ch.valid  <= 1'b0;
  endtask

  initial begin : stimulus
    int unsigned fed;
    int unsigned n;
    // Drive every input to a known value before the first edge.
    score_ch.valid       = 1'b0;
    score_ch.var_score   = '0;
    score_ch.is_last     = 1'b0;
    score_ch.random_word = '0;
    flip_ch.ready        = 1'b0;
    cfg_ch.valid         = 1'b0;
    cfg_ch.clause_count  = '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // Directed scans at the reset clause count.
    send_idle_pct = 16;
    recv_idle_pct = 88;
    push_beat(-65535, 1'b1, 32'h0000_0000);      // lone improving variable
    push_beat(65535, 1'b1, 32'hFFFF_FFFF);       // ties the start, not improving
    push_beat(-5, 1'b0, 32'h0);                  // three-way tie
    push_beat(-5, 1'b0, 32'h0);
    push_beat(-5, 1'b1, 32'hFFFF_FFFF);
    push_beat(0, 1'b0, 32'h0);                   // lower score drops the ties
    push_beat(-1, 1'b0, 32'h0);
    push_beat(-7, 1'b0, 32'h0);
    push_beat(-7, 1'b0, 32'h0);
    push_beat(-2, 1'b1, 32'h0000_0001);
    push_beat(3, 1'b0, 32'h0);                   // minimum reaches zero: restart
    push_beat(2, 1'b0, 32'h0);
    push_beat(0, 1'b1, 32'h5555_AAAA);
    push_beat(-1, 1'b0, 32'h0);
    push_beat(-65535, 1'b1, 32'hAAAA_5555);
    push_beat(65535, 1'b0, 32'h0);               // all non-improving
    push_beat(1, 1'b1, 32'h1234_5678);
    wait_drained();

    // Random phases: each sets a clause count and a stall mix.
    for (int ph = 0; ph < 3; ph++) begin
      case (ph)
        0: begin
          write_clause_count('0);
          send_idle_pct = 16;
          recv_idle_pct = 88;
        end
        1: begin
          write_clause_count(CLAUSE_W'($urandom_range(1, 12)));
          send_idle_pct = 88;
          recv_idle_pct = 16;
        end
        default: begin
          write_clause_count(CLAUSE_RST);
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase
      fed = 0;
      while (fed < PHASE_BEATS) begin
        n = ($urandom_range(99) < 85) ? $urandom_range(1, 16) : $urandom_range(17, 120);
        queue_scan(n);
        fed += n;
      end
      wait_drained();
    end

    if (err_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

// ----- best_flip_candidate_select.f -----
design/bfcs_pkg.sv
design/bfcs_ifs.sv
design/bfcs_ram.sv
design/bfcs_ctrl.sv
design/bfcs_dpath.sv
design/best_flip_candidate_select.sv
tb/sv/best_flip_candidate_select_test.sv
